[hdl/pida_pkg.sv]
// Shared types and constants for the positional insert/delete array.
package pida_pkg;

  // Default and largest supported element capacity
  localparam int CAPACITY_DEF = 64;
  localparam int CAPACITY_MAX = 1024;

  // Width of a position or a count at the largest capacity
  localparam int POS_W = $clog2(CAPACITY_MAX + 1);

  // Fixed field widths of the request and result beats
  localparam int FUNC_W   = 3;
  localparam int INDEX_W  = 7;
  localparam int WORD_W   = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FN_READ   = 3'd0,
    FN_WRITE  = 3'd1,
    FN_APPEND = 3'd2,
    FN_INSERT = 3'd3,
    FN_DELETE = 3'd4,
    FN_SETCNT = 3'd5
  } pida_func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_TOO_BIG   = 2'd3
  } pida_status_t;

  // Operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4
  } pida_op_t;

  // Command bus from the controller to the cell row
  typedef struct packed {
    logic             go;
    pida_op_t         op;
    logic [POS_W-1:0] index;
    logic [POS_W-1:0] count;
  } pida_cmd_t;

endpackage

[hdl/pida_cell.sv]
// One storage cell of the array: holds a word and trades it with its neighbours.
module pida_cell #(
  parameter int POS = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pida_pkg::pida_cmd_t                  cmd,
  input  logic [pida_pkg::WORD_W-1:0]          value,
  input  logic [pida_pkg::WORD_W-1:0]          prev_data,
  input  logic [pida_pkg::WORD_W-1:0]          next_data,
  output logic [pida_pkg::WORD_W-1:0]          data,
  output logic [pida_pkg::WORD_W-1:0]          rd_data
);

  localparam logic [pida_pkg::POS_W-1:0] POS_C  = pida_pkg::POS_W'(POS);
  localparam logic [pida_pkg::POS_W-1:0] POS1_C = pida_pkg::POS_W'(POS + 1);

  logic [pida_pkg::WORD_W-1:0] data_r, data_nxt;
  logic [pida_pkg::WORD_W-1:0] rd_r, rd_nxt;
  logic                        hit;

  assign hit = (cmd.index == POS_C);

  // Pick the next word: load, take from below on insert, from above on delete
  always_comb begin
    data_nxt = data_r;
    rd_nxt   = rd_r;
    if (cmd.go) begin
      rd_nxt = '0;
      case (cmd.op)
        pida_pkg::OP_READ: begin
          if (hit) rd_nxt = data_r;
        end
        pida_pkg::OP_WRITE: begin
          if (hit) data_nxt = value;
        end
        pida_pkg::OP_INSERT: begin
          if (hit) begin
            data_nxt = value;
          end else if ((POS_C > cmd.index) && (POS_C <= cmd.count)) begin
            data_nxt = prev_data;
          end
        end
        pida_pkg::OP_DELETE: begin
          if ((POS_C >= cmd.index) && (POS1_C < cmd.count)) data_nxt = next_data;
        end
        default: ;
      endcase
    end
  end

  // Hold the word and the masked read-out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
      rd_r   <= '0;
    end else begin
      data_r <= data_nxt;
      rd_r   <= rd_nxt;
    end
  end

  assign data    = data_r;
  assign rd_data = rd_r;

endmodule

[hdl/positional_insert_delete_array.sv]
// An accepted request beat is held in the first stage, then in the output register,
// before its result beat shows on out_tvalid. Throughput: one request per cycle unless
// out_tready stalls output; every cell shifts at once, at any insert or delete position.
// The read-out is an OR over all cells' registered masked words, one stage deep.
// Reset clears every cell and the count to zero in the same cycle; no clearing pass.
module positional_insert_delete_array #(
  parameter int CAPACITY = pida_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: func[2:0], index[9:3], value[73:10], new_size[80:74], zero pad
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: status[1:0], read_value[65:2], count_now[72:66], zero pad
  output logic [79:0] out_tdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [pida_pkg::POS_W-1:0] CAP_C = pida_pkg::POS_W'(CAPACITY);

  // Request fields
  pida_pkg::pida_func_t                in_func;
  logic [pida_pkg::INDEX_W-1:0]        in_index;
  logic [pida_pkg::WORD_W-1:0]         in_value;
  logic [pida_pkg::INDEX_W-1:0]        in_new_size;

  assign in_func     = pida_pkg::pida_func_t'(in_tdata[2:0]);
  assign in_index    = in_tdata[9:3];
  assign in_value    = in_tdata[73:10];
  assign in_new_size = in_tdata[80:74];

  logic in_acc;
  logic p1_move;

  logic [CW-1:0]               count_r, count_nxt;
  logic [pida_pkg::POS_W-1:0]  cnt_ext, idx_ext, nsz_ext, cnt_nxt_ext;
  pida_pkg::pida_status_t      status;
  pida_pkg::pida_op_t          op;
  logic [pida_pkg::POS_W-1:0]  op_index;
  pida_pkg::pida_cmd_t         cmd;

  logic                         p1_valid_r;
  pida_pkg::pida_status_t       p1_status_r;
  logic [pida_pkg::COUNT_W-1:0] p1_count_r;

  logic                         out_valid_r;
  pida_pkg::pida_status_t       out_status_r;
  logic [pida_pkg::WORD_W-1:0]  out_rd_r;
  logic [pida_pkg::COUNT_W-1:0] out_count_r;

  logic [pida_pkg::WORD_W-1:0]  cell_data [CAPACITY];
  logic [pida_pkg::WORD_W-1:0]  cell_rd   [CAPACITY];
  logic [pida_pkg::WORD_W-1:0]  rd_or;

  // Take a request when the first stage is empty or drains this cycle
  assign p1_move   = !out_valid_r || out_tready;
  assign in_tready = !p1_valid_r || p1_move;
  assign in_acc    = in_tvalid && in_tready;

  assign cnt_ext     = pida_pkg::POS_W'(count_r);
  assign idx_ext     = pida_pkg::POS_W'(in_index);
  assign nsz_ext     = pida_pkg::POS_W'(in_new_size);
  assign cnt_nxt_ext = pida_pkg::POS_W'(count_nxt);

  // Check the request against the count and pick the cell operation
  always_comb begin
    status    = pida_pkg::ST_OK;
    op        = pida_pkg::OP_NONE;
    op_index  = idx_ext;
    count_nxt = count_r;
    case (in_func)
      pida_pkg::FN_READ: begin
        if (idx_ext < cnt_ext) op = pida_pkg::OP_READ;
        else status = pida_pkg::ST_BAD_INDEX;
      end
      pida_pkg::FN_WRITE: begin
        if (idx_ext < cnt_ext) op = pida_pkg::OP_WRITE;
        else status = pida_pkg::ST_BAD_INDEX;
      end
      pida_pkg::FN_APPEND: begin
        if (cnt_ext == CAP_C) begin
          status = pida_pkg::ST_FULL;
        end else begin
          op        = pida_pkg::OP_INSERT;
          op_index  = cnt_ext;
          count_nxt = count_r + CW'(1);
        end
      end
      pida_pkg::FN_INSERT: begin
        if (idx_ext > cnt_ext) begin
          status = pida_pkg::ST_BAD_INDEX;
        end else if (cnt_ext == CAP_C) begin
          status = pida_pkg::ST_FULL;
        end else begin
          op        = pida_pkg::OP_INSERT;
          count_nxt = count_r + CW'(1);
        end
      end
      pida_pkg::FN_DELETE: begin
        if (idx_ext < cnt_ext) begin
          op        = pida_pkg::OP_DELETE;
          count_nxt = count_r - CW'(1);
        end else begin
          status = pida_pkg::ST_BAD_INDEX;
        end
      end
      pida_pkg::FN_SETCNT: begin
        if (nsz_ext > CAP_C) status = pida_pkg::ST_TOO_BIG;
        else count_nxt = CW'(in_new_size);
      end
      default: ;
    endcase
  end

  // Broadcast the command to the row
  always_comb begin
    cmd.go    = in_acc;
    cmd.op    = in_acc ? op : pida_pkg::OP_NONE;
    cmd.index = op_index;
    cmd.count = cnt_ext;
  end

  // Row of cells, each wired to its neighbours; the end cells see zero beyond the row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [pida_pkg::WORD_W-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_lo
      assign prev_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_hi
      assign next_w = cell_data[i+1];
    end
    pida_cell #(
      .POS(i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .value     (in_value),
      .prev_data (prev_w),
      .next_data (next_w),
      .data      (cell_data[i]),
      .rd_data   (cell_rd[i])
    );
  end

  // Merge the masked read-outs; only the addressed cell is non-zero
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) rd_or = rd_or | cell_rd[i];
  end

  // Advance the count and the first stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      p1_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r    <= count_nxt;
        p1_valid_r <= 1'b1;
      end else if (p1_move) begin
        p1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_status_r <= status;
      p1_count_r  <= cnt_nxt_ext[pida_pkg::COUNT_W-1:0];
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p1_move) begin
      out_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move && p1_valid_r) begin
      out_status_r <= p1_status_r;
      out_rd_r     <= rd_or;
      out_count_r  <= p1_count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_count_r, out_rd_r, out_status_r};

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pida_pkg::POS_W'(count_r) <= CAP_C)
    else $error("element count above capacity");

  a_count_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(count_r))
    else $error("element count moved without a request");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> p1_valid_r)
    else $error("accepted request lost before the first stage");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r && (p1_status_r == pida_pkg::ST_FULL) |-> (pida_pkg::POS_W'(count_r) == CAP_C))
    else $error("full status reported while below capacity");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != pida_pkg::ST_OK) |-> (out_rd_r == '0))
    else $error("failed request returned a non-zero word");
`endif

endmodule

[test/positional_insert_delete_array_tb.sv]
// Self-checking testbench for the positional insert/delete array: directed table, then random requests.
module positional_insert_delete_array_tb;

  localparam int ARRAY_CAP = pida_pkg::CAPACITY_DEF;
  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;
  localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] FIVES = 64'h5555_5555_5555_5555;
  localparam logic [63:0] AAAS  = 64'hAAAA_AAAA_AAAA_AAAA;

  typedef struct {
    logic [2:0]  func;
    logic [6:0]  index;
    logic [63:0] value;
    logic [6:0]  new_size;
  } array_req_t;

  typedef struct {
    pida_pkg::pida_status_t status;
    logic [63:0]            read_value;
    logic [6:0]             count_now;
  } array_resp_t;

  typedef struct {
    array_req_t  req;
    bit          typed;
    array_resp_t resp;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;

  // Shadow copy of the array state
  logic [63:0] shadow_words [ARRAY_CAP];
  int          shadow_count;

  array_resp_t pending_resp [$];
  dir_row_t    directed_rows [$];
  int          fail_count;
  int          idle_pct;
  int          stall_pct;
  bit          fill_up;

  // Beat currently on the request bus: typed expectation, if any
  bit          hold_typed;
  array_resp_t hold_resp;

  positional_insert_delete_array DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Apply one request to the shadow array and return the result it gives
  function automatic array_resp_t apply_request(array_req_t q);
    array_resp_t r;
    int          pos;
    r.status     = pida_pkg::ST_OK;
    r.read_value = '0;
    case (q.func)
      pida_pkg::FN_READ: begin
        if (q.index < shadow_count) r.read_value = shadow_words[q.index];
        else r.status = pida_pkg::ST_BAD_INDEX;
      end
      pida_pkg::FN_WRITE: begin
        if (q.index < shadow_count) shadow_words[q.index] = q.value;
        else r.status = pida_pkg::ST_BAD_INDEX;
      end
      pida_pkg::FN_APPEND: begin
        if (shadow_count >= ARRAY_CAP) begin
          r.status = pida_pkg::ST_FULL;
        end else begin
          shadow_words[shadow_count] = q.value;
          shadow_count++;
        end
      end
      pida_pkg::FN_INSERT: begin
        if (q.index > shadow_count) begin
          r.status = pida_pkg::ST_BAD_INDEX;
        end else if (shadow_count >= ARRAY_CAP) begin
          r.status = pida_pkg::ST_FULL;
        end else begin
          for (pos = shadow_count; pos > q.index; pos--)
            shadow_words[pos] = shadow_words[pos-1];
          shadow_words[q.index] = q.value;
          shadow_count++;
        end
      end
      pida_pkg::FN_DELETE: begin
        if (q.index < shadow_count) begin
          // vacated top slot keeps its old word
          for (pos = q.index; pos + 1 < shadow_count; pos++)
            shadow_words[pos] = shadow_words[pos+1];
          shadow_count--;
        end else begin
          r.status = pida_pkg::ST_BAD_INDEX;
        end
      end
      pida_pkg::FN_SETCNT: begin
        if (q.new_size > ARRAY_CAP) r.status = pida_pkg::ST_TOO_BIG;
        else shadow_count = q.new_size;
      end
      default: ;
    endcase
    r.count_now = 7'(shadow_count);
    return r;
  endfunction

  // Predict on each accepted request beat, check each accepted result beat
  always @(posedge clk) begin : scoreboard
    array_req_t  q;
    array_resp_t want;
    array_resp_t got;
    if (rst_n && in_tvalid && in_tready) begin
      q.func     = in_tdata[2:0];
      q.index    = in_tdata[9:3];
      q.value    = in_tdata[73:10];
      q.new_size = in_tdata[80:74];
      want = apply_request(q);
      if (hold_typed) pending_resp.push_back(hold_resp);
      else pending_resp.push_back(want);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.status     = pida_pkg::pida_status_t'(out_tdata[1:0]);
      got.read_value = out_tdata[65:2];
      got.count_now  = out_tdata[72:66];
      if (pending_resp.size() == 0) begin
        $error("result beat with no request waiting");
        fail_count++;
      end else begin
        want = pending_resp.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.read_value !== want.read_value) begin
          $error("read_value: expected %0h, got %0h", want.read_value, got.read_value);
          fail_count++;
        end
        if (got.count_now !== want.count_now) begin
          $error("count_now: expected %0d, got %0d", want.count_now, got.count_now);
          fail_count++;
        end
      end
    end
  end

  // Stall the result channel at the current rate
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic row_typed(logic [2:0] f, int idx, logic [63:0] v, int nsz,
                           pida_pkg::pida_status_t st, logic [63:0] rd, int cnt);
    dir_row_t w;
    w.req.func          = f;
    w.req.index         = 7'(idx);
    w.req.value         = v;
    w.req.new_size      = 7'(nsz);
    w.typed             = 1'b1;
    w.resp.status       = st;
    w.resp.read_value   = rd;
    w.resp.count_now    = 7'(cnt);
    directed_rows.push_back(w);
  endtask

  task automatic row_checked(logic [2:0] f, int idx, logic [63:0] v, int nsz);
    dir_row_t w;
    w.req.func     = f;
    w.req.index    = 7'(idx);
    w.req.value    = v;
    w.req.new_size = 7'(nsz);
    w.typed        = 1'b0;
    w.resp.status  = pida_pkg::ST_OK;
    w.resp.read_value = '0;
    w.resp.count_now  = '0;
    directed_rows.push_back(w);
  endtask

  // Present one request beat, called at a falling edge; returns once accepted
  task automatic present(dir_row_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    hold_typed = w.typed;
    hold_resp  = w.resp;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, w.req.new_size, w.req.value, w.req.index, w.req.func};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold off the sender until every result has come back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_resp.size() != 0) @(negedge clk);
  endtask

  // Random request, mostly in range for the current count
  function automatic dir_row_t random_row();
    dir_row_t w;
    int       pick;
    bit       in_range;
    pick     = $urandom_range(99);
    in_range = ($urandom_range(99) < 88);
    if (pick < 20) w.req.func = pida_pkg::FN_READ;
    else if (pick < 32) w.req.func = pida_pkg::FN_WRITE;
    else if (pick < 62) begin
      if (!fill_up) w.req.func = pida_pkg::FN_DELETE;
      else if (pick < 46) w.req.func = pida_pkg::FN_APPEND;
      else w.req.func = pida_pkg::FN_INSERT;
    end else if (pick < 80) begin
      case (pick % 3)
        0: w.req.func = pida_pkg::FN_APPEND;
        1: w.req.func = pida_pkg::FN_INSERT;
        default: w.req.func = pida_pkg::FN_DELETE;
      endcase
    end else if (pick < 88) w.req.func = pida_pkg::FN_SETCNT;
    else w.req.func = 3'($urandom_range(7));

    w.req.index = 7'($urandom_range(127));
    if (in_range) begin
      if (w.req.func == pida_pkg::FN_INSERT) w.req.index = 7'($urandom_range(shadow_count));
      else if (shadow_count > 0) w.req.index = 7'($urandom_range(shadow_count - 1));
    end
    w.req.value    = {$urandom, $urandom};
    w.req.new_size = ($urandom_range(99) < 85) ? 7'($urandom_range(ARRAY_CAP))
                                               : 7'($urandom_range(127));
    w.typed           = 1'b0;
    w.resp.status     = pida_pkg::ST_OK;
    w.resp.read_value = '0;
    w.resp.count_now  = '0;
    return w;
  endfunction

  initial begin : stimulus
    int idle_set  [4] = '{0, 67, 0, 29};
    int stall_set [4] = '{0, 0, 67, 29};
    int ph;
    int n;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    fail_count   = 0;
    fill_up      = 1'b1;
    hold_typed   = 1'b0;
    shadow_count = 0;
    foreach (shadow_words[i]) shadow_words[i] = '0;

    // Empty array: every positional request fails, bad counts are refused
    row_typed(pida_pkg::FN_READ,   0,   '0,   0,   pida_pkg::ST_BAD_INDEX, '0, 0);
    row_typed(pida_pkg::FN_DELETE, 0,   '0,   0,   pida_pkg::ST_BAD_INDEX, '0, 0);
    row_typed(pida_pkg::FN_WRITE,  0,   ONES, 0,   pida_pkg::ST_BAD_INDEX, '0, 0);
    row_typed(pida_pkg::FN_INSERT, 1,   ONES, 0,   pida_pkg::ST_BAD_INDEX, '0, 0);
    row_typed(pida_pkg::FN_SETCNT, 0,   '0,   127, pida_pkg::ST_TOO_BIG,   '0, 0);
    row_typed(pida_pkg::FN_SETCNT, 0,   '0,   65,  pida_pkg::ST_TOO_BIG,   '0, 0);
    row_typed(FN_SPARE6,           127, ONES, 127, pida_pkg::ST_OK,        '0, 0);
    row_typed(FN_SPARE7,           0,   '0,   0,   pida_pkg::ST_OK,        '0, 0);
    // Fill a few slots, insert at the front and at the count
    row_typed(pida_pkg::FN_APPEND, 0,   ONES,  0,  pida_pkg::ST_OK,        '0, 1);
    row_typed(pida_pkg::FN_INSERT, 0,   '0,    0,  pida_pkg::ST_OK,        '0, 2);
    row_typed(pida_pkg::FN_INSERT, 2,   FIVES, 0,  pida_pkg::ST_OK,        '0, 3);
    row_typed(pida_pkg::FN_READ,   1,   '0,    0,  pida_pkg::ST_OK,        ONES, 3);
    row_typed(pida_pkg::FN_WRITE,  0,   AAAS,  0,  pida_pkg::ST_OK,        '0, 3);
    row_typed(pida_pkg::FN_DELETE, 0,   '0,    0,  pida_pkg::ST_OK,        '0, 2);
    row_checked(pida_pkg::FN_READ, 0,   '0,    0);
    // Grow to capacity: returning slots keep their old words
    row_typed(pida_pkg::FN_SETCNT, 0,   '0,    64, pida_pkg::ST_OK,        '0, 64);
    row_checked(pida_pkg::FN_READ, 2,   '0,    0);
    row_typed(pida_pkg::FN_APPEND, 0,   ONES,  0,  pida_pkg::ST_FULL,      '0, 64);
    row_typed(pida_pkg::FN_INSERT, 64,  ONES,  0,  pida_pkg::ST_FULL,      '0, 64);
    row_typed(pida_pkg::FN_INSERT, 127, ONES,  0,  pida_pkg::ST_BAD_INDEX, '0, 64);
    row_typed(pida_pkg::FN_READ,   64,  '0,    0,  pida_pkg::ST_BAD_INDEX, '0, 64);
    row_typed(pida_pkg::FN_READ,   127, '0,    0,  pida_pkg::ST_BAD_INDEX, '0, 64);
    row_checked(pida_pkg::FN_DELETE, 63, '0,   0);
    row_checked(pida_pkg::FN_INSERT, 0, AAAS,  0);
    row_checked(pida_pkg::FN_READ, 63,  '0,    0);
    row_typed(pida_pkg::FN_SETCNT, 0,   '0,    0,  pida_pkg::ST_OK,        '0, 0);

    // Hold reset, then release it once
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      @(negedge clk);
      present(directed_rows[i]);
    end
    drain();

    // Random requests under each idling pattern, drained between phases
    for (ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      for (n = 0; n < 450; n++) begin
        @(negedge clk);
        if ($urandom_range(99) == 0) fill_up = !fill_up;
        present(random_row());
      end
      drain();
    end

    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
hdl/pida_pkg.sv
hdl/pida_cell.sv
hdl/positional_insert_delete_array.sv
test/positional_insert_delete_array_tb.sv
